// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clock, reset_n, pre, post) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clock, reset_n, pre, post) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clock, reset_n, pre, post)
`define ASSERT_NEXT(label, clock, reset_n, pre, post)
`endif
`endif

// ----- sv/bnds_pkg.sv -----
// ---------------------------------------------------------------------------
// Block nesting depth scanner package
// Types, character codes and keyword tables shared by the scanner modules.
// ---------------------------------------------------------------------------
package bnds_pkg;

    localparam int WINDOW_LEN = 7;
    localparam int SEEN_W     = 3;
    localparam int KW_BITS    = 48;
    localparam int OPENER_CNT = 9;

    typedef logic [7:0] char_t;

    localparam char_t CH_LF      = 8'h0A;
    localparam char_t CH_SPACE   = 8'h20;
    localparam char_t CH_DQUOTE  = 8'h22;
    localparam char_t CH_HASH    = 8'h23;
    localparam char_t CH_SQUOTE  = 8'h27;
    localparam char_t CH_RPAREN  = 8'h29;
    localparam char_t CH_DOT     = 8'h2E;
    localparam char_t CH_BSLASH  = 8'h5C;
    localparam char_t CH_LBRACE  = 8'h7B;
    localparam char_t CH_BAR     = 8'h7C;
    localparam char_t CH_RBRACE  = 8'h7D;

    typedef enum logic [1:0] {
        MODE_CODE,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_COMMENT
    } scan_mode_t;

    typedef struct packed {
        logic [WINDOW_LEN-1:0][7:0] bytes;
        logic [WINDOW_LEN-1:0]      in_code;
        logic [SEEN_W-1:0]          seen;
    } window_t;

    typedef struct packed {
        logic  fire;
        char_t text;
        logic  last;
    } step_t;

    typedef struct packed {
        logic up;
        logic down;
    } kw_event_t;

    localparam logic [KW_BITS-1:0] OPENER_TEXT [OPENER_CNT] = '{
        "def", "class", "module", "if", "unless", "case", "while", "until", "for"
    };
    localparam int OPENER_LEN [OPENER_CNT] = '{3, 5, 6, 2, 6, 4, 5, 5, 3};

    localparam logic [KW_BITS-1:0] KW_BEGIN = "begin";
    localparam logic [KW_BITS-1:0] KW_DO    = "do";
    localparam logic [KW_BITS-1:0] KW_END   = "end";

    function automatic logic is_word_char(input char_t c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
               ((c >= "0") && (c <= "9")) || (c == "_");
    endfunction

    // Words are stored right-justified with their first letter highest.
    function automatic logic word_ends(
        input window_t            win,
        input char_t              cur,
        input logic [KW_BITS-1:0] text,
        input int                 k,
        input int                 endback
    );
        int    s;
        int    b;
        logic  hit;
        char_t ch;
        s   = k - 1 + endback;
        hit = 1'b1;
        if ((k < 2) || (s > WINDOW_LEN) || (int'(win.seen) < s)) begin
            hit = 1'b0;
        end else begin
            for (int i = 0; i < k; i++) begin
                b  = s - i;
                ch = (b == 0) ? cur : win.bytes[3'(b - 1)];
                if (ch != text[8*(k-1-i) +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (!win.in_code[3'(s - 1)]) begin
                hit = 1'b0;
            end
            if ((s + 1 <= WINDOW_LEN) && (int'(win.seen) >= s + 1)) begin
                if (is_word_char(win.bytes[3'(s)])) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

endpackage

// ----- sv/block_nesting_depth_scanner.sv -----
// ---------------------------------------------------------------------------
// Block nesting depth scanner
// Scans source text one byte per transaction and reports the open block
// depth when the final byte of a text arrives.
//
//   channel  direction  handshake                 fields
//   text     in         text_valid / text_stall   text_byte, final_byte
//   depth    out        depth_valid / depth_stall open_depth
//
// One byte is accepted per cycle unless a final byte waits on a stalled result.
// The window, mode and depth registers in the scan core update once per byte.
// Reset and each final byte return the scanner to the start of a text.
// A stalled result holds back only a following final byte and the bytes behind it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module block_nesting_depth_scanner
    import bnds_pkg::*;
#(
    parameter int DEPTH_WIDTH = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    output logic       depth_valid,
    input  logic       depth_stall,
    output logic [7:0] open_depth
);

    logic       hold_valid_reg;
    logic [7:0] text_byte_reg;
    logic       final_byte_reg;
    logic       depth_valid_reg;
    logic [7:0] open_depth_reg;
    logic       advance;
    logic [7:0] result_depth;
    step_t      step;

    assign advance = hold_valid_reg &&
                     (!final_byte_reg || !depth_valid_reg || !depth_stall);
    assign text_stall  = hold_valid_reg && !advance;
    assign depth_valid = depth_valid_reg;
    assign open_depth  = open_depth_reg;

    assign step.fire = advance;
    assign step.text = text_byte_reg;
    assign step.last = final_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg  <= 1'b0;
            depth_valid_reg <= 1'b0;
        end
        else
        begin
            if (text_valid && !text_stall)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (advance && final_byte_reg)
            begin
                depth_valid_reg <= 1'b1;
            end
            else if (!depth_stall)
            begin
                depth_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall)
        begin
            text_byte_reg  <= text_byte;
            final_byte_reg <= final_byte;
        end
        if (advance && final_byte_reg)
        begin
            open_depth_reg <= result_depth;
        end
    end

    bnds_scan_core #(
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .result_depth (result_depth)
    );

    `ASSERT_NEXT(a_result_from_final, clk, rst_n, advance && final_byte_reg, depth_valid_reg)
    `ASSERT_IMPLY(a_no_stall_when_empty, clk, rst_n, !depth_valid_reg, !text_stall)
    `ASSERT_NEXT(a_final_waits, clk, rst_n, text_stall,
                 hold_valid_reg && final_byte_reg && $stable(text_byte_reg))

endmodule

// ----- sv/bnds_keyword_match.sv -----
// ---------------------------------------------------------------------------
// Keyword matcher
// Compares the recent byte window against all keywords in parallel and
// reports whether the current byte confirms an opening or closing keyword.
// ---------------------------------------------------------------------------
module bnds_keyword_match
    import bnds_pkg::*;
(
    input  window_t   win,
    input  char_t     text,
    input  logic      last,
    output kw_event_t kw_event
);

    logic common_term;
    logic opener_hit;

    always_comb
    begin
        common_term = (text == CH_LF) || (text == CH_SPACE) || (text == CH_HASH);
        opener_hit  = 1'b0;
        for (int i = 0; i < OPENER_CNT; i++)
        begin
            if (word_ends(win, text, OPENER_TEXT[i], OPENER_LEN[i], 1))
            begin
                opener_hit = 1'b1;
            end
        end
        kw_event.up = ((text == CH_SPACE) && opener_hit) ||
                      (common_term && word_ends(win, text, KW_BEGIN, 5, 1)) ||
                      ((common_term || (text == CH_BAR)) && word_ends(win, text, KW_DO, 2, 1)) ||
                      (last && (word_ends(win, text, KW_BEGIN, 5, 0) ||
                                word_ends(win, text, KW_DO, 2, 0)));
        kw_event.down = ((common_term || (text == CH_DOT) || (text == CH_RPAREN)) &&
                         word_ends(win, text, KW_END, 3, 1)) ||
                        (last && word_ends(win, text, KW_END, 3, 0));
    end

endmodule

// ----- sv/bnds_scan_core.sv -----
// ---------------------------------------------------------------------------
// Scan core
// Holds the scan mode, byte window and depth counter; updates them for one
// byte per cycle on step.fire. Produces the saturated depth for a final byte.
// ---------------------------------------------------------------------------
module bnds_scan_core
    import bnds_pkg::*;
#(
    parameter int DEPTH_WIDTH = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  step_t      step,
    output logic [7:0] result_depth
);

    localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = {DEPTH_WIDTH{1'b1}};

    scan_mode_t              mode_reg, mode_next;
    logic                    quote_reg, quote_next;
    window_t                 win_reg, win_next;
    logic [DEPTH_WIDTH-1:0]  depth_reg, depth_next, depth_upd;
    logic [DEPTH_WIDTH+7:0]  depth_ext;
    logic                    brace_up, brace_down;
    kw_event_t               kw_event;

    bnds_keyword_match u_match
    (
        .win      (win_reg),
        .text     (step.text),
        .last     (step.last),
        .kw_event (kw_event)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_CODE;
            quote_reg <= 1'b0;
            win_reg   <= '0;
            depth_reg <= '0;
        end
        else if (step.fire)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            win_reg   <= win_next;
            depth_reg <= depth_next;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        brace_up   = 1'b0;
        brace_down = 1'b0;
        case (mode_reg)
            MODE_CODE:
            begin
                if ((step.text == CH_DQUOTE) || (step.text == CH_SQUOTE))
                begin
                    mode_next  = MODE_STRING;
                    quote_next = (step.text == CH_SQUOTE);
                end
                else if (step.text == CH_HASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else
                begin
                    brace_up   = (step.text == CH_LBRACE);
                    brace_down = (step.text == CH_RBRACE);
                end
            end
            MODE_STRING:
            begin
                if (step.text == CH_BSLASH)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else if (step.text == (quote_reg ? CH_SQUOTE : CH_DQUOTE))
                begin
                    mode_next = MODE_CODE;
                end
            end
            MODE_ESCAPE:
            begin
                mode_next = MODE_STRING;
            end
            MODE_COMMENT:
            begin
                if (step.text == CH_LF)
                begin
                    mode_next = MODE_CODE;
                end
            end
            default:
            begin
                mode_next = MODE_CODE;
            end
        endcase

        // At most one depth event can occur for any single byte.
        depth_upd = depth_reg;
        if ((kw_event.up || brace_up) && (depth_reg != DEPTH_MAX))
        begin
            depth_upd = depth_reg + 1'b1;
        end
        else if ((kw_event.down || brace_down) && (depth_reg != '0))
        begin
            depth_upd = depth_reg - 1'b1;
        end

        depth_ext    = {8'd0, depth_upd};
        result_depth = (depth_ext > (DEPTH_WIDTH+8)'(255)) ? 8'hFF : depth_ext[7:0];

        win_next.bytes   = {win_reg.bytes[WINDOW_LEN-2:0], step.text};
        win_next.in_code = {win_reg.in_code[WINDOW_LEN-2:0], (mode_reg == MODE_CODE)};
        win_next.seen    = (win_reg.seen == SEEN_W'(WINDOW_LEN)) ? win_reg.seen
                                                                  : win_reg.seen + 1'b1;
        depth_next       = depth_upd;

        if (step.last)
        begin
            mode_next  = MODE_CODE;
            quote_next = 1'b0;
            win_next   = '0;
            depth_next = '0;
        end
    end

endmodule
